// ----- src/fscl_pkg.sv -----
package fscl_pkg;

  localparam int unsigned DATA_W        = 8;
  localparam int unsigned LIMIT_W       = 16;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000);
  localparam int unsigned BIT_CNT_W     = $clog2(DATA_W);

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_DATA   = 2'd2,
    ACT_FINISH = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE        = 3'd0,
    ST_BUSY        = 3'd1,
    ST_READY       = 3'd2,
    ST_DONE_OK     = 3'd3,
    ST_INIT_LOW_TO = 3'd4,
    ST_INIT_HI_TO  = 3'd5,
    ST_LOAD_ERR    = 3'd6,
    ST_DONE_TO     = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_WAIT_LOW  = 3'd1,
    PH_WAIT_HIGH = 3'd2,
    PH_READY     = 3'd3,
    PH_FINISH    = 3'd4
  } phase_e;

  typedef enum logic {
    CFG_WAIT_LIMIT = 1'b0,
    CFG_DONE_LIMIT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    action_e           action;
    logic [DATA_W-1:0] data_byte;
    logic              init_level;
    logic              done_level;
  } in_item_t;

  typedef struct packed {
    logic    prog_level;
    logic    drive_enable;
    logic    data_level;
    logic    clock_pulse;
    status_e status;
    logic    last;
  } out_item_t;

  // One classified item: either a single result or a byte to serialize.
  typedef struct packed {
    logic              is_byte;
    logic [DATA_W-1:0] data_byte;
    logic              prog_level;
    logic              drive_enable;
    logic              clock_pulse;
    status_e           status;
  } cmd_t;

endpackage

// ----- src/fpga_serial_config_loader_top.sv -----
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_ready_o   | in_data_i (in_item_t)
// out     | output    | out_valid_o/out_ready_i | out_data_o (out_item_t)
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A data byte in the ready phase yields eight results, one per cycle from the
// serializer while the output is not stalled; every other item yields one result.
// Items are classified in the cycle they are accepted and queued for the
// serializer, so input is taken every cycle until the command queue fills.
// Reset restores both limits to 1000, the idle phase and a high program line.
// Configuration writes are taken in any cycle.
module fpga_serial_config_loader_top #(
  parameter int unsigned QueueDepth = fscl_pkg::QUEUE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  fscl_pkg::in_item_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output fscl_pkg::out_item_t          out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  fscl_pkg::cfg_reg_e           cfg_index_i,
  input  logic [fscl_pkg::LIMIT_W-1:0] cfg_data_i
);
  import fscl_pkg::*;

  logic cmd_valid, cmd_ready, q_valid, q_ready;
  cmd_t cmd, q_cmd;

  fscl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  fscl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_valid),
    .push_ready_o (cmd_ready),
    .push_data_i  (cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_cmd)
  );

  fscl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- src/fscl_front.sv -----
module fscl_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  fscl_pkg::in_item_t      in_data_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  fscl_pkg::cfg_reg_e      cfg_index_i,
  input  logic [fscl_pkg::LIMIT_W-1:0] cfg_data_i,
  output logic                    cmd_valid_o,
  input  logic                    cmd_ready_i,
  output fscl_pkg::cmd_t          cmd_o
);
  import fscl_pkg::*;

  phase_e             phase_q, phase_d;
  logic [LIMIT_W-1:0] wait_count_q, wait_count_d;
  logic [LIMIT_W-1:0] finish_clocks_q, finish_clocks_d;
  logic               prog_q, prog_d;
  logic [LIMIT_W-1:0] wait_limit_q, done_limit_q, cfg_value;
  logic [LIMIT_W-1:0] wait_inc, fc_base, fc_inc;
  logic               wait_to, done_to, in_fire;

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign in_fire     = in_valid_i && cmd_ready_i;
  assign cfg_ready_o = 1'b1;

  // A limit of zero behaves like a limit of one.
  assign cfg_value = (cfg_data_i == '0) ? LIMIT_W'(1) : cfg_data_i;

  assign wait_inc = wait_count_q + LIMIT_W'(1);
  assign wait_to  = wait_inc >= wait_limit_q;
  // Finish in the ready phase starts a fresh clock count.
  assign fc_base  = (phase_q == PH_READY) ? '0 : finish_clocks_q;
  assign fc_inc   = fc_base + LIMIT_W'(1);
  assign done_to  = fc_inc >= done_limit_q;

  always_comb begin
    phase_d = phase_q;
    case (in_data_i.action)
      ACT_START: phase_d = PH_WAIT_LOW;
      ACT_TICK: begin
        case (phase_q)
          PH_WAIT_LOW: begin
            if (!in_data_i.init_level) phase_d = PH_WAIT_HIGH;
            else if (wait_to)          phase_d = PH_IDLE;
          end
          PH_WAIT_HIGH: begin
            if (in_data_i.init_level) phase_d = PH_READY;
            else if (wait_to)         phase_d = PH_IDLE;
          end
          PH_FINISH: begin
            if (in_data_i.done_level || done_to) phase_d = PH_IDLE;
          end
          default: phase_d = phase_q;
        endcase
      end
      ACT_DATA: begin
        if (phase_q == PH_READY && !in_data_i.init_level) phase_d = PH_IDLE;
      end
      ACT_FINISH: begin
        if (phase_q == PH_READY) begin
          phase_d = (in_data_i.done_level || done_to) ? PH_IDLE : PH_FINISH;
        end
      end
      default: phase_d = phase_q;
    endcase
  end

  always_comb begin
    wait_count_d    = wait_count_q;
    finish_clocks_d = finish_clocks_q;
    prog_d          = prog_q;
    cmd_o.is_byte      = 1'b0;
    cmd_o.data_byte    = in_data_i.data_byte;
    cmd_o.drive_enable = (phase_q != PH_IDLE);
    cmd_o.clock_pulse  = 1'b0;
    case (phase_q)
      PH_IDLE:  cmd_o.status = ST_IDLE;
      PH_READY: cmd_o.status = ST_READY;
      default:  cmd_o.status = ST_BUSY;
    endcase
    case (in_data_i.action)
      ACT_START: begin
        prog_d             = 1'b0;
        wait_count_d       = '0;
        finish_clocks_d    = '0;
        cmd_o.drive_enable = 1'b1;
        cmd_o.status       = ST_BUSY;
      end
      ACT_TICK: begin
        case (phase_q)
          PH_WAIT_LOW: begin
            if (!in_data_i.init_level) begin
              prog_d       = 1'b1;
              wait_count_d = '0;
            end else begin
              wait_count_d = wait_inc;
              if (wait_to) begin
                prog_d       = 1'b1;
                cmd_o.status = ST_INIT_LOW_TO;
              end
            end
          end
          PH_WAIT_HIGH: begin
            if (in_data_i.init_level) begin
              cmd_o.status = ST_READY;
            end else begin
              wait_count_d = wait_inc;
              if (wait_to) cmd_o.status = ST_INIT_HI_TO;
            end
          end
          PH_FINISH: begin
            if (in_data_i.done_level) begin
              cmd_o.status = ST_DONE_OK;
            end else begin
              finish_clocks_d   = fc_inc;
              cmd_o.clock_pulse = 1'b1;
              cmd_o.status      = done_to ? ST_DONE_TO : ST_BUSY;
            end
          end
          default: cmd_o.status = cmd_o.status;
        endcase
      end
      ACT_DATA: begin
        if (phase_q == PH_READY) begin
          cmd_o.is_byte     = 1'b1;
          cmd_o.clock_pulse = 1'b1;
          cmd_o.status      = in_data_i.init_level ? ST_READY : ST_LOAD_ERR;
        end
      end
      ACT_FINISH: begin
        if (phase_q == PH_READY) begin
          if (in_data_i.done_level) begin
            finish_clocks_d = '0;
            cmd_o.status    = ST_DONE_OK;
          end else begin
            finish_clocks_d   = fc_inc;
            cmd_o.clock_pulse = 1'b1;
            cmd_o.status      = done_to ? ST_DONE_TO : ST_BUSY;
          end
        end
      end
      default: cmd_o.status = cmd_o.status;
    endcase
    cmd_o.prog_level = prog_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_IDLE;
      wait_count_q    <= '0;
      finish_clocks_q <= '0;
      prog_q          <= 1'b1;
    end else if (in_fire) begin
      phase_q         <= phase_d;
      wait_count_q    <= wait_count_d;
      finish_clocks_q <= finish_clocks_d;
      prog_q          <= prog_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_limit_q <= LIMIT_RESET;
      done_limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WAIT_LIMIT: wait_limit_q <= cfg_value;
        CFG_DONE_LIMIT: done_limit_q <= cfg_value;
        default:        wait_limit_q <= wait_limit_q;
      endcase
    end
  end

endmodule

// ----- src/fscl_queue.sv -----
module fscl_queue #(
  parameter int unsigned Depth = fscl_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  fscl_pkg::cmd_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output fscl_pkg::cmd_t pop_data_o
);
  import fscl_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop)      count_q <= count_q + CntW'(1);
      else if (pop && !push) count_q <= count_q - CntW'(1);
    end
  end

endmodule

// ----- src/fscl_back.sv -----
module fscl_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  fscl_pkg::cmd_t      cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fscl_pkg::out_item_t out_data_o
);
  import fscl_pkg::*;

  logic                 out_valid_q;
  out_item_t            out_q;
  logic                 busy_q;
  logic [DATA_W-1:0]    shift_q;
  logic [BIT_CNT_W-1:0] bit_cnt_q;
  logic                 prog_q;
  status_e              final_q;
  logic                 advance;

  assign advance     = !out_valid_q || out_ready_i;
  assign cmd_ready_o = advance && !busy_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Bytes go out MSB first; only the eighth bit carries the final status.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (busy_q) begin
        out_q.prog_level   <= prog_q;
        out_q.drive_enable <= 1'b1;
        out_q.data_level   <= shift_q[DATA_W-1];
        out_q.clock_pulse  <= 1'b1;
        out_q.last         <= (bit_cnt_q == BIT_CNT_W'(DATA_W - 1));
        out_q.status       <= (bit_cnt_q == BIT_CNT_W'(DATA_W - 1)) ? final_q : ST_READY;
        shift_q            <= shift_q << 1;
      end else if (cmd_valid_i) begin
        out_q.prog_level   <= cmd_i.prog_level;
        out_q.drive_enable <= cmd_i.drive_enable;
        out_q.clock_pulse  <= cmd_i.clock_pulse;
        if (cmd_i.is_byte) begin
          out_q.data_level <= cmd_i.data_byte[DATA_W-1];
          out_q.status     <= ST_READY;
          out_q.last       <= 1'b0;
        end else begin
          out_q.data_level <= 1'b0;
          out_q.status     <= cmd_i.status;
          out_q.last       <= 1'b1;
        end
        shift_q <= cmd_i.data_byte << 1;
        prog_q  <= cmd_i.prog_level;
        final_q <= cmd_i.status;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      busy_q      <= 1'b0;
      bit_cnt_q   <= '0;
    end else if (advance) begin
      if (busy_q) begin
        out_valid_q <= 1'b1;
        bit_cnt_q   <= bit_cnt_q + BIT_CNT_W'(1);
        if (bit_cnt_q == BIT_CNT_W'(DATA_W - 1)) busy_q <= 1'b0;
      end else if (cmd_valid_i) begin
        out_valid_q <= 1'b1;
        busy_q      <= cmd_i.is_byte;
        bit_cnt_q   <= BIT_CNT_W'(1);
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fscl_pkg::*;

  // Tracks the configuration session as the loader sees it and holds the pin
  // results that each accepted transaction should produce, oldest first.
  class session_predictor;
    phase_e             phase;
    logic [LIMIT_W-1:0] wait_limit;
    logic [LIMIT_W-1:0] done_limit;
    logic [LIMIT_W-1:0] wait_count;
    logic [LIMIT_W-1:0] finish_clocks;
    logic               prog_out;
    out_item_t          expected_pins[$];
    int                 fails;
    int                 items_noted;
    int                 bytes_shifted;
    int                 results_checked;
    int                 status_hits[8];

    function new();
      phase         = PH_IDLE;
      wait_limit    = LIMIT_RESET;
      done_limit    = LIMIT_RESET;
      wait_count    = '0;
      finish_clocks = '0;
      prog_out      = 1'b1;
      fails         = 0;
      items_noted   = 0;
      bytes_shifted = 0;
      results_checked = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function int pending();
      return expected_pins.size();
    endfunction

    // A limit of zero behaves as a limit of one.
    function void set_limit(cfg_reg_e idx, logic [LIMIT_W-1:0] val);
      logic [LIMIT_W-1:0] v;
      v = (val == '0) ? LIMIT_W'(1) : val;
      if (idx == CFG_WAIT_LIMIT) begin
        wait_limit = v;
      end else begin
        done_limit = v;
      end
    endfunction

    function void push(logic drv, logic dat, logic clkp, status_e st, logic last);
      out_item_t r;
      r.prog_level   = prog_out;
      r.drive_enable = drv;
      r.data_level   = dat;
      r.clock_pulse  = clkp;
      r.status       = st;
      r.last         = last;
      expected_pins.push_back(r);
      status_hits[int'(st)]++;
    endfunction

    // One sample of the done line; a low done costs one finish clock.
    function void sample_done(logic done);
      if (done) begin
        phase = PH_IDLE;
        push(1'b1, 1'b0, 1'b0, ST_DONE_OK, 1'b1);
      end else begin
        finish_clocks = finish_clocks + 1'b1;
        if (finish_clocks >= done_limit) begin
          phase = PH_IDLE;
          push(1'b1, 1'b0, 1'b1, ST_DONE_TO, 1'b1);
        end else begin
          phase = PH_FINISH;
          push(1'b1, 1'b0, 1'b1, ST_BUSY, 1'b1);
        end
      end
    endfunction

    function void note_item(in_item_t it);
      status_e st;
      items_noted++;
      if (it.action == ACT_START) begin
        prog_out      = 1'b0;
        wait_count    = '0;
        finish_clocks = '0;
        phase         = PH_WAIT_LOW;
        push(1'b1, 1'b0, 1'b0, ST_BUSY, 1'b1);
      end else if (it.action == ACT_DATA && phase == PH_READY) begin
        bytes_shifted++;
        for (int j = 0; j < 8; j++) begin
          st = ST_READY;
          if (j == 7 && !it.init_level) begin
            st    = ST_LOAD_ERR;
            phase = PH_IDLE;
          end
          push(1'b1, it.data_byte[7-j], 1'b1, st, j == 7);
        end
      end else if (it.action == ACT_FINISH && phase == PH_READY) begin
        finish_clocks = '0;
        sample_done(it.done_level);
      end else if (it.action == ACT_TICK && phase == PH_WAIT_LOW) begin
        if (!it.init_level) begin
          prog_out   = 1'b1;
          wait_count = '0;
          phase      = PH_WAIT_HIGH;
          push(1'b1, 1'b0, 1'b0, ST_BUSY, 1'b1);
        end else begin
          wait_count = wait_count + 1'b1;
          if (wait_count >= wait_limit) begin
            prog_out = 1'b1;
            phase    = PH_IDLE;
            push(1'b1, 1'b0, 1'b0, ST_INIT_LOW_TO, 1'b1);
          end else begin
            push(1'b1, 1'b0, 1'b0, ST_BUSY, 1'b1);
          end
        end
      end else if (it.action == ACT_TICK && phase == PH_WAIT_HIGH) begin
        if (it.init_level) begin
          phase = PH_READY;
          push(1'b1, 1'b0, 1'b0, ST_READY, 1'b1);
        end else begin
          wait_count = wait_count + 1'b1;
          if (wait_count >= wait_limit) begin
            phase = PH_IDLE;
            push(1'b1, 1'b0, 1'b0, ST_INIT_HI_TO, 1'b1);
          end else begin
            push(1'b1, 1'b0, 1'b0, ST_BUSY, 1'b1);
          end
        end
      end else if (it.action == ACT_TICK && phase == PH_FINISH) begin
        sample_done(it.done_level);
      end else begin
        // Out-of-place transactions only report where the session stands.
        case (phase)
          PH_IDLE:  st = ST_IDLE;
          PH_READY: st = ST_READY;
          default:  st = ST_BUSY;
        endcase
        push(phase != PH_IDLE, 1'b0, 1'b0, st, 1'b1);
      end
    endfunction

    function void compare_field(string name, logic [2:0] want, logic [2:0] got);
      if (got !== want) begin
        $error("%s expected %0d got %0d", name, want, got);
        fails++;
      end
    endfunction

    function void check_pins(out_item_t got);
      out_item_t want;
      if (expected_pins.size() == 0) begin
        $error("result with no transaction pending: %p", got);
        fails++;
        return;
      end
      want = expected_pins.pop_front();
      results_checked++;
      compare_field("prog_level", want.prog_level, got.prog_level);
      compare_field("drive_enable", want.drive_enable, got.drive_enable);
      compare_field("data_level", want.data_level, got.data_level);
      compare_field("clock_pulse", want.clock_pulse, got.clock_pulse);
      compare_field("status", want.status, got.status);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  in_item_t           in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  out_item_t          out_data_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  cfg_reg_e           cfg_index_i;
  logic [LIMIT_W-1:0] cfg_data_i;

  session_predictor sb = new();
  logic tx_steady = 1'b0;
  logic rx_steady = 1'b0;
  int   rx_hold_req = 0;

  fpga_serial_config_loader_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Results are sampled at the edge and checked a little later, so that a
  // transaction accepted at the same edge is always noted first.
  initial begin : result_monitor
    out_item_t seen;
    logic      took;
    int        hold_left;
    out_ready_i = 1'b0;
    hold_left   = 0;
    forever begin
      @(posedge clk_i);
      took = out_valid_o && out_ready_i;
      seen = out_data_o;
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= rx_steady || ($urandom_range(0, 99) >= 25);
      end
      #1;
      if (took) sb.check_pins(seen);
    end
  end

  task automatic push_item(in_item_t it);
    int gap;
    gap = 0;
    while (!tx_steady && $urandom_range(0, 99) < 25) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(it);
  endtask

  task automatic send_item(action_e act, logic [7:0] b, logic init, logic done);
    in_item_t it;
    it.action     = act;
    it.data_byte  = b;
    it.init_level = init;
    it.done_level = done;
    push_item(it);
  endtask

  // Mostly the transaction that moves the current session forward, with
  // random content; about one in ten is arbitrary noise.
  task automatic send_shaped_item(output logic shaped);
    in_item_t it;
    int       r;
    it.action     = action_e'($urandom_range(0, 3));
    it.data_byte  = 8'($urandom);
    it.init_level = 1'($urandom_range(0, 1));
    it.done_level = 1'($urandom_range(0, 1));
    shaped = ($urandom_range(0, 99) >= 10);
    if (shaped) begin
      r = $urandom_range(0, 99);
      case (sb.phase)
        PH_IDLE: it.action = ACT_START;
        PH_WAIT_LOW: begin
          it.action     = ACT_TICK;
          it.init_level = (r >= 35);
        end
        PH_WAIT_HIGH: begin
          it.action     = ACT_TICK;
          it.init_level = (r < 35);
        end
        PH_READY: begin
          if (r < 75) begin
            it.action     = ACT_DATA;
            it.init_level = ($urandom_range(0, 99) >= 8);
          end else begin
            it.action     = ACT_FINISH;
            it.done_level = ($urandom_range(0, 99) < 30);
          end
        end
        default: begin
          it.action     = ACT_TICK;
          it.done_level = (r < 30);
        end
      endcase
    end
    push_item(it);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_limits(logic [LIMIT_W-1:0] wait_val, logic [LIMIT_W-1:0] done_val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_WAIT_LIMIT;
    cfg_data_i  <= wait_val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_limit(CFG_WAIT_LIMIT, wait_val);
    cfg_index_i <= CFG_DONE_LIMIT;
    cfg_data_i  <= done_val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_limit(CFG_DONE_LIMIT, done_val);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    int   counted;
    logic shaped;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_WAIT_LIMIT;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A session on the reset limits that ends in a load error, transactions out of place, then a full session.
    send_item(ACT_START, 8'hFF, 1'b1, 1'b1);
    send_item(ACT_TICK, 8'h00, 1'b1, 1'b0);
    send_item(ACT_TICK, 8'h00, 1'b0, 1'b0);
    send_item(ACT_TICK, 8'h00, 1'b1, 1'b0);
    send_item(ACT_TICK, 8'h00, 1'b1, 1'b1);
    send_item(ACT_DATA, 8'h00, 1'b1, 1'b0);
    send_item(ACT_DATA, 8'hFF, 1'b1, 1'b1);
    send_item(ACT_DATA, 8'hA5, 1'b0, 1'b0);
    send_item(ACT_TICK, 8'hFF, 1'b1, 1'b1);
    send_item(ACT_DATA, 8'h3C, 1'b1, 1'b1);
    send_item(ACT_FINISH, 8'h00, 1'b0, 1'b0);
    send_item(ACT_START, 8'h00, 1'b0, 1'b0);
    send_item(ACT_TICK, 8'h00, 1'b0, 1'b0);
    send_item(ACT_TICK, 8'h00, 1'b1, 1'b0);
    send_item(ACT_FINISH, 8'h00, 1'b0, 1'b1);

    // A zero wait limit acts as one, so a wait that does not see its level on its first tick times out on that tick.
    drain_results();
    write_limits('0, 16'd2);
    send_item(ACT_START, 8'h00, 1'b0, 1'b0);
    send_item(ACT_TICK, 8'h00, 1'b1, 1'b0);
    send_item(ACT_START, 8'h00, 1'b0, 1'b0);
    send_item(ACT_TICK, 8'h00, 1'b0, 1'b0);
    send_item(ACT_TICK, 8'h00, 1'b0, 1'b0);
    send_item(ACT_START, 8'h00, 1'b0, 1'b0);
    send_item(ACT_TICK, 8'h00, 1'b0, 1'b0);
    send_item(ACT_TICK, 8'h00, 1'b1, 1'b0);
    send_item(ACT_START, 8'h81, 1'b1, 1'b1);
    send_item(ACT_TICK, 8'h00, 1'b0, 1'b0);
    send_item(ACT_TICK, 8'h00, 1'b1, 1'b0);
    send_item(ACT_FINISH, 8'h00, 1'b1, 1'b0);
    send_item(ACT_TICK, 8'h00, 1'b1, 1'b0);

    for (int blk = 0; blk < 5; blk++) begin
      drain_results();
      case (blk)
        0: write_limits(16'd4, 16'd3);
        1: write_limits('0, 16'd1);
        2: write_limits(16'hFFFF, 16'hFFFF);
        3: write_limits(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)));
        default: write_limits(16'd2, 16'd5);
      endcase
      rx_steady = (blk == 2);
      tx_steady = (blk == 0 || blk == 2);
      // The receiver holds off while the sender keeps offering, so the
      // command queue fills and input stalls.
      if (blk == 0) rx_hold_req = 80;
      counted = 0;
      while (counted < 15) begin
        send_shaped_item(shaped);
        if (shaped) counted++;
        if (blk == 0 && counted == 10) tx_steady = 1'b0;
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d transactions, %0d bytes shifted, %0d results checked.",
             sb.items_noted, sb.bytes_shifted, sb.results_checked);
    $display("Outcomes: %0d done ok, %0d init timeouts, %0d load errors, %0d done timeouts.",
             sb.status_hits[int'(ST_DONE_OK)],
             sb.status_hits[int'(ST_INIT_LOW_TO)] + sb.status_hits[int'(ST_INIT_HI_TO)],
             sb.status_hits[int'(ST_LOAD_ERR)], sb.status_hits[int'(ST_DONE_TO)]);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
